[hw/rtl/bgpw_pkg.sv]
// Shared types, constants and helpers for the bitmap glyph pixel writer.
// No dependencies; every other file imports this package.
package bgpw_pkg;

  localparam int GLYPH_COUNT = 128;
  localparam int GLYPH_ROWS  = 8;
  localparam int CELL_MAX    = 8;
  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
  localparam logic [31:0] ON_WORD  = 32'h00FF_FFFF;
  localparam logic [31:0] OFF_WORD = 32'h0000_0000;

  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH     = 3'd0,
    REG_GLYPH_HEIGHT    = 3'd1,
    REG_ROW_PITCH       = 3'd2,
    REG_BYTES_PER_PIXEL = 3'd3,
    REG_FONT_IS_8X8     = 3'd4,
    REG_FRAME_BASE      = 3'd5
  } reg_index_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_DRAW = 1'b1
  } mode_t;

  typedef struct packed {
    logic [3:0]  glyph_width;
    logic [3:0]  glyph_height;
    logic [15:0] row_pitch;
    logic [2:0]  bytes_per_pixel;
    logic        font_is_8x8;
    logic [31:0] frame_base;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [6:0]  glyph_code;
    logic [2:0]  row_index;
    logic [7:0]  row_bits;
    logic [31:0] start_address;
  } item_t;

  function automatic logic [3:0] clamp_cell(logic [3:0] v);
    clamp_cell = (v > 4'(CELL_MAX)) ? 4'(CELL_MAX) : v;
  endfunction

  function automatic logic row_in_store(logic [2:0] row);
    row_in_store = ({1'b0, row} < 4'(GLYPH_ROWS));
  endfunction

  function automatic logic [STORE_AW-1:0] store_index(logic [6:0] code, logic [2:0] row);
    int unsigned idx;
    idx = (int'(code) % GLYPH_COUNT) * GLYPH_ROWS + int'(row);
    store_index = STORE_AW'(idx);
  endfunction

endpackage

[hw/rtl/bgpw_front.sv]
// Front end: input register that takes each beat and precomputes the address terms.
// Pushes classified items into the queue. Depends on bgpw_pkg.
module bgpw_front import bgpw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [6:0]  glyph_code,
  input  logic [2:0]  row_index,
  input  logic [7:0]  row_bits,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic        queue_full,
  output logic        push,
  output item_t       push_item
);

  logic        f1_valid;
  mode_t       f1_mode;
  logic [6:0]  f1_code;
  logic [2:0]  f1_row_index;
  logic [7:0]  f1_row_bits;
  logic [27:0] f1_y_term;
  logic [14:0] f1_x_term;
  logic        accept;

  assign in_stall = f1_valid && queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f1_valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (push) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_mode      <= mode_t'(mode);
      f1_code      <= glyph_code;
      f1_row_index <= row_index;
      f1_row_bits  <= row_bits;
      f1_y_term    <= 28'(pos_y) * 28'(cfg.row_pitch);
      f1_x_term    <= 15'(pos_x) * 15'(cfg.bytes_per_pixel);
    end
  end

  always_comb begin
    push_item.mode          = f1_mode;
    push_item.glyph_code    = f1_code;
    push_item.row_index     = f1_row_index;
    push_item.row_bits      = f1_row_bits;
    push_item.start_address = cfg.frame_base + 32'(f1_y_term) + 32'(f1_x_term);
  end

endmodule

[hw/rtl/bgpw_queue.sv]
// Short item queue between front and back ends.
// Depends on bgpw_pkg for the item type and depth.
module bgpw_queue import bgpw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  empty
);

  item_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_CW-1:0]  count;

  assign full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[hw/rtl/bgpw_back.sv]
// Back end: glyph store, cell sequencer, store read stage and output register.
// Depends on bgpw_pkg.
module bgpw_back import bgpw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  item_t       head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] write_address,
  output logic [31:0] pixel_word,
  output logic        last_pixel
);

  logic [7:0] store [STORE_DEPTH];

  logic [2:0]  row;
  logic [2:0]  col;
  logic [31:0] row_addr;
  logic [31:0] cell_addr;

  logic        b_valid;
  logic [31:0] b_addr;
  logic [2:0]  b_col;
  logic        b_last;
  logic        b_font;
  logic        b_row_ok;
  logic [7:0]  b_bits;

  logic [3:0]  w;
  logic [3:0]  h;
  logic        is_load;
  logic        no_cells;
  logic        col_end;
  logic        row_end;
  logic        first;
  logic        c_ready;
  logic        b_ready;
  logic        emit;
  logic        load_write;
  logic [31:0] cur_addr;
  logic [31:0] next_row_addr;

  assign w        = clamp_cell(cfg.glyph_width);
  assign h        = clamp_cell(cfg.glyph_height);
  assign is_load  = (head.mode == MODE_LOAD);
  assign no_cells = (w == 4'd0) || (h == 4'd0);
  assign col_end  = ({1'b0, col} == w - 4'd1);
  assign row_end  = ({1'b0, row} == h - 4'd1);
  assign first    = (row == 3'd0) && (col == 3'd0);

  assign c_ready  = !out_valid || !out_stall;
  assign b_ready  = !b_valid || c_ready;
  assign emit     = !empty && !is_load && !no_cells && b_ready;
  assign pop      = !empty && (is_load || no_cells || (emit && col_end && row_end));
  assign load_write = !empty && is_load && row_in_store(head.row_index);

  assign cur_addr      = first ? head.start_address : cell_addr;
  assign next_row_addr = ((row == 3'd0) ? head.start_address : row_addr)
                         + 32'(cfg.row_pitch);

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (emit) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? 3'd0 : row + 3'd1;
      end else begin
        col <= col + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (col_end) begin
        row_addr  <= next_row_addr;
        cell_addr <= next_row_addr;
      end else begin
        cell_addr <= cur_addr + 32'(cfg.bytes_per_pixel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_write) begin
      store[store_index(head.glyph_code, head.row_index)] <= head.row_bits;
    end
    if (emit) begin
      b_bits <= store[store_index(head.glyph_code, row)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (emit) begin
      b_valid <= 1'b1;
    end else if (c_ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      b_addr   <= cur_addr;
      b_col    <= col;
      b_last   <= col_end && row_end;
      b_font   <= cfg.font_is_8x8;
      b_row_ok <= row_in_store(row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_valid && c_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && c_ready) begin
      write_address <= b_addr;
      pixel_word    <= (!b_font || (b_row_ok && b_bits[b_col])) ? ON_WORD : OFF_WORD;
      last_pixel    <= b_last;
    end
  end

endmodule

[hw/rtl/bitmap_glyph_pixel_writer.sv]
// Top level of the bitmap glyph pixel writer: config registers, front, queue, back.
// Depends on bgpw_pkg, bgpw_front, bgpw_queue and bgpw_back.
//
//   channel | handshake            | beat contents
//   in      | in_valid / in_stall  | mode, glyph_code, row_index, row_bits, pos_x, pos_y
//   out     | out_valid/ out_stall | write_address, pixel_word, last_pixel
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// A draw item yields min(w,8)*min(h,8) beats, one per cycle from the cell sequencer
// while out_stall does not hold it; a load item writes the glyph store and yields no beat.
// Reset is synchronous and clears all control state; the glyph store is not cleared.
// The queue lets the front keep taking beats while out_stall holds the back end, until it is full.
module bitmap_glyph_pixel_writer import bgpw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [6:0]  glyph_code,
  input  logic [2:0]  row_index,
  input  logic [7:0]  row_bits,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] write_address,
  output logic [31:0] pixel_word,
  output logic        last_pixel
);

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  item_t head;
  logic  empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_width     <= 4'd8;
      cfg.glyph_height    <= 4'd8;
      cfg.row_pitch       <= 16'd4096;
      cfg.bytes_per_pixel <= 3'd4;
      cfg.font_is_8x8     <= 1'b1;
      cfg.frame_base      <= 32'd0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_GLYPH_WIDTH:     cfg.glyph_width     <= cfg_data[3:0];
        REG_GLYPH_HEIGHT:    cfg.glyph_height    <= cfg_data[3:0];
        REG_ROW_PITCH:       cfg.row_pitch       <= cfg_data[15:0];
        REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= cfg_data[2:0];
        REG_FONT_IS_8X8:     cfg.font_is_8x8     <= cfg_data[0];
        REG_FRAME_BASE:      cfg.frame_base      <= cfg_data;
        default: ;
      endcase
    end
  end

  bgpw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .glyph_code (glyph_code),
    .row_index  (row_index),
    .row_bits   (row_bits),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  bgpw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  bgpw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .write_address (write_address),
    .pixel_word    (pixel_word),
    .last_pixel    (last_pixel)
  );

endmodule

[hw/rtl/bgpw_checker.sv]
// Port-level checks for the bitmap glyph pixel writer, bound to the top level.
// Depends on bgpw_pkg and bitmap_glyph_pixel_writer.
module bgpw_checker import bgpw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] write_address,
  input logic [31:0] pixel_word,
  input logic        last_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(write_address)
      && $stable(pixel_word) && $stable(last_pixel))
    else $error("stalled output beat changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("handshake active right after reset");

  a_pixel_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_word == ON_WORD || pixel_word == OFF_WORD)
    else $error("pixel word is neither on nor off");

endmodule

bind bitmap_glyph_pixel_writer bgpw_checker u_bgpw_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .write_address (write_address),
  .pixel_word    (pixel_word),
  .last_pixel    (last_pixel)
);

[tb/sv/tb_bitmap_glyph_pixel_writer.sv]
// Self-checking testbench for bitmap_glyph_pixel_writer: loads glyph rows, draws characters
// under many register settings and checks every pixel write against its own prediction.
// Depends on bgpw_pkg and the RTL of bitmap_glyph_pixel_writer.
module tb_bitmap_glyph_pixel_writer;
  import bgpw_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;

  typedef struct {
    mode_t       mode;
    logic [6:0]  code;
    logic [2:0]  row;
    logic [7:0]  bits;
    logic [11:0] x;
    logic [11:0] y;
  } text_item_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] word;
    logic        last;
  } pixel_write_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [6:0]  glyph_code;
  logic [2:0]  row_index;
  logic [7:0]  row_bits;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] write_address;
  logic [31:0] pixel_word;
  logic        last_pixel;

  logic [3:0]  sh_width  = 4'd8;
  logic [3:0]  sh_height = 4'd8;
  logic [15:0] sh_pitch  = 16'd4096;
  logic [2:0]  sh_bpp    = 3'd4;
  logic        sh_font   = 1'b1;
  logic [31:0] sh_base   = 32'd0;

  logic [7:0]   glyph_rows [STORE_DEPTH];
  logic [7:0]   row_mask [GLYPH_COUNT];
  logic [6:0]   ready_codes [$];
  pixel_write_t pixel_expect [$];

  int  items_sent  = 0;
  int  bad_writes  = 0;
  int  idle_cycles = 0;
  bit  tx_steady   = 1'b0;
  bit  rx_steady   = 1'b0;
  bit  hold_output = 1'b0;

  bitmap_glyph_pixel_writer u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .glyph_code    (glyph_code),
    .row_index     (row_index),
    .row_bits      (row_bits),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .write_address (write_address),
    .pixel_word    (pixel_word),
    .last_pixel    (last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void predict_glyph_writes(input text_item_t it);
    int unsigned  wc;
    int unsigned  hc;
    logic [7:0]   pattern;
    pixel_write_t pw;
    if (it.mode == MODE_LOAD) begin
      glyph_rows[{it.code, it.row}] = it.bits;
      if (row_mask[it.code] != 8'hFF) begin
        row_mask[it.code][it.row] = 1'b1;
        if (row_mask[it.code] == 8'hFF) ready_codes.push_back(it.code);
      end
    end else begin
      wc = (sh_width > 4'd8) ? 8 : sh_width;
      hc = (sh_height > 4'd8) ? 8 : sh_height;
      for (int unsigned r = 0; r < hc; r++) begin
        for (int unsigned c = 0; c < wc; c++) begin
          pattern = sh_font ? glyph_rows[{it.code, r[2:0]}] : 8'hFF;
          pw.addr = sh_base + (32'(it.y) + r) * 32'(sh_pitch) + (32'(it.x) + c) * 32'(sh_bpp);
          pw.word = pattern[c] ? ON_WORD : OFF_WORD;
          pw.last = (r + 1 == hc) && (c + 1 == wc);
          pixel_expect.push_back(pw);
        end
      end
    end
  endfunction

  function automatic logic [11:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 12'd0;
    if (pick == 1) return 12'hFFF;
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic text_item_t load_item(input logic [6:0] code, input logic [2:0] row,
                                           input logic [7:0] bits);
    text_item_t it;
    it.mode = MODE_LOAD;
    it.code = code;
    it.row  = row;
    it.bits = bits;
    it.x    = 12'($urandom_range(0, 4095));
    it.y    = 12'($urandom_range(0, 4095));
    return it;
  endfunction

  function automatic text_item_t draw_item(input logic [6:0] code, input logic [11:0] x,
                                           input logic [11:0] y);
    text_item_t it;
    it.mode = MODE_DRAW;
    it.code = code;
    it.row  = 3'($urandom_range(0, 7));
    it.bits = 8'($urandom_range(0, 255));
    it.x    = x;
    it.y    = y;
    return it;
  endfunction

  // Hold the beat until taken; valid stays high on return.
  task automatic send_item(input text_item_t it);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= it.mode;
    glyph_code <= it.code;
    row_index  <= it.row;
    row_bits   <= it.bits;
    pos_x      <= it.x;
    pos_y      <= it.y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_glyph_writes(it);
    items_sent++;
  endtask

  task automatic drain_writes();
    in_valid <= 1'b0;
    while (pixel_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [3:0] w, input logic [3:0] h,
                               input logic [15:0] pitch, input logic [2:0] bpp,
                               input logic font, input logic [31:0] base);
    drain_writes();
    write_reg(REG_GLYPH_WIDTH, 32'(w));
    write_reg(REG_GLYPH_HEIGHT, 32'(h));
    write_reg(REG_ROW_PITCH, 32'(pitch));
    write_reg(REG_BYTES_PER_PIXEL, 32'(bpp));
    write_reg(REG_FONT_IS_8X8, 32'(font));
    write_reg(REG_FRAME_BASE, base);
    cfg_we    <= 1'b0;
    sh_width  = w;
    sh_height = h;
    sh_pitch  = pitch;
    sh_bpp    = bpp;
    sh_font   = font;
    sh_base   = base;
  endtask

  function automatic logic [3:0] random_dim();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 4'd0;
    if (pick == 1) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  task automatic apply_random_setting();
    logic [15:0] pitch;
    logic [2:0]  bpp;
    int unsigned pick;
    pick  = $urandom_range(0, 5);
    pitch = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    bpp   = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    apply_setting(random_dim(), random_dim(), pitch, bpp, $urandom_range(0, 3) != 0, $urandom);
  endtask

  function automatic logic [6:0] pick_drawable();
    if (sh_font && ready_codes.size() != 0)
      return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
    return 7'($urandom_range(0, 127));
  endfunction

  // Load all rows of one glyph in shuffled order, then draw it.
  task automatic send_glyph_sequence();
    logic [6:0]  code;
    int unsigned order [8];
    int unsigned j;
    int unsigned tmp;
    code = 7'($urandom_range(0, 127));
    foreach (order[i]) order[i] = i;
    for (int i = 7; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) send_item(load_item(code, 3'(order[i]), 8'($urandom_range(0, 255))));
    repeat ($urandom_range(1, 3)) send_item(draw_item(code, random_coord(), random_coord()));
  endtask

  task automatic send_noise_item();
    if ($urandom_range(0, 2) == 0 || (sh_font && ready_codes.size() == 0))
      send_item(load_item(7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255))));
    else
      send_item(draw_item(pick_drawable(), random_coord(), random_coord()));
  endtask

  task automatic send_mixed_traffic(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 9) < 6) send_glyph_sequence();
      else send_noise_item();
    end
  endtask

  task automatic test_directed_glyphs();
    logic [7:0] top_rows [8] = '{8'h01, 8'h80, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h0F, 8'hF0};
    logic [7:0] low_rows [8] = '{8'hFF, 8'h7E, 8'h3C, 8'h18, 8'h18, 8'h3C, 8'h7E, 8'hFF};
    for (int r = 0; r < 8; r++) send_item(load_item(7'd127, 3'(r), top_rows[r]));
    for (int r = 7; r >= 0; r--) send_item(load_item(7'd0, 3'(r), low_rows[r]));
    send_item(draw_item(7'd127, 12'd0, 12'd0));
    send_item(draw_item(7'd127, 12'hFFF, 12'hFFF));
    send_item(draw_item(7'd0, 12'hFFF, 12'd0));
  endtask

  task automatic test_setting_corners();
    apply_setting(4'd15, 4'd15, 16'hFFFF, 3'd7, 1'b1, 32'hFFFF_FFF0);
    send_item(draw_item(7'd127, 12'hFFF, 12'hFFF));
    apply_setting(4'd0, 4'd5, 16'd100, 3'd2, 1'b1, 32'd0);
    send_item(draw_item(7'd0, 12'd10, 12'd20));
    apply_setting(4'd6, 4'd0, 16'd100, 3'd2, 1'b1, 32'd0);
    send_item(draw_item(7'd127, 12'd10, 12'd20));
    apply_setting(4'd8, 4'd8, 16'd0, 3'd0, 1'b0, 32'h8000_0000);
    send_item(draw_item(7'd42, 12'd123, 12'd456));
    apply_setting(4'd1, 4'd1, 16'd1, 3'd1, 1'b1, 32'd0);
    send_item(draw_item(7'd0, 12'd0, 12'd0));
    apply_setting(4'd3, 4'd5, 16'd320, 3'd3, 1'b1, 32'd1000);
    send_item(draw_item(7'd127, 12'd7, 12'd9));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) apply_setting(4'd8, 4'd8, 16'hFFFF, 3'd4, 1'b1, 32'hFFFF_FFFF);
      else if (phase == 1) apply_setting(4'd1, 4'd1, 16'd0, 3'd1, 1'b1, 32'd0);
      else apply_random_setting();
      send_mixed_traffic(40);
    end
  endtask

  task automatic test_back_to_back();
    apply_setting(4'd4, 4'd3, 16'd800, 3'd4, 1'b1, $urandom);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_mixed_traffic(20);
    drain_writes();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    apply_setting(4'd8, 4'd8, 16'd4096, 3'd1, 1'b1, $urandom);
    hold_output = 1'b1;
    tx_steady   = 1'b1;
    repeat (12) send_item(draw_item(pick_drawable(), random_coord(), random_coord()));
    tx_steady = 1'b0;
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_GLYPH_WIDTH;
    cfg_data   <= 32'd0;
    in_valid   <= 1'b0;
    mode       <= MODE_LOAD;
    glyph_code <= 7'd0;
    row_index  <= 3'd0;
    row_bits   <= 8'd0;
    pos_x      <= 12'd0;
    pos_y      <= 12'd0;
    foreach (row_mask[i]) row_mask[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_glyphs();
    test_setting_corners();
    test_random_traffic();
    test_back_to_back();
    test_output_backpressure();
    drain_writes();
    if (bad_writes == 0 && pixel_expect.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : rx_side
    int unsigned wait_n;
    out_stall <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        wait_n = rx_steady ? 0 : $urandom_range(0, 9);
        if (wait_n != 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_writes
    pixel_write_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (pixel_expect.size() == 0) begin
        bad_writes++;
        if (bad_writes <= 10)
          $display("unexpected write: addr %h word %h last %b",
                   write_address, pixel_word, last_pixel);
      end else begin
        exp_w = pixel_expect.pop_front();
        if (exp_w.addr !== write_address || exp_w.word !== pixel_word ||
            exp_w.last !== last_pixel) begin
          bad_writes++;
          if (bad_writes <= 10)
            $display("write mismatch: expected addr %h word %h last %b, got addr %h word %h last %b",
                     exp_w.addr, exp_w.word, exp_w.last, write_address, pixel_word, last_pixel);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
